@@ rtl/hsvctm_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvctm_pkg
// shared widths, register indexes and pipeline stage types for the hsv
// color threshold mask
// ----------------------------------------------------------------------------
package hsvctm_pkg;

  localparam int unsigned CH_W      = 8;   // color channel width
  localparam int unsigned CFG_IDX_W = 3;   // register index width
  localparam int unsigned CFG_W     = 8;   // widest register
  localparam int unsigned NUM_W     = 16;  // hue and saturation numerators

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_LOW  = 3'd0,
    CFG_HUE_HIGH = 3'd1,
    CFG_SAT_LOW  = 3'd2,
    CFG_SAT_HIGH = 3'd3,
    CFG_VAL_LOW  = 3'd4,
    CFG_VAL_HIGH = 3'd5
  } cfg_idx_t;

  // input register contents
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            coords_finite;
  } stage_a_t;

  // exact rationals after the color conversion
  typedef struct packed {
    logic [NUM_W-1:0] hn;      // half-hue numerator
    logic [CH_W-1:0]  hd;      // half-hue denominator
    logic [NUM_W-1:0] sn;      // saturation*255 numerator
    logic [CH_W-1:0]  sd;      // saturation denominator
    logic [CH_W-1:0]  mx;      // value
    logic             finite;
  } stage_b_t;

endpackage

@@ rtl/hsvctm_if.sv @@
// ----------------------------------------------------------------------------
// hsvctm_in_if / hsvctm_out_if
// valid/ready channels for color items and keep results
// ----------------------------------------------------------------------------
interface hsvctm_in_if;
  import hsvctm_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            coords_finite;

  modport source (output valid, output red, output green, output blue,
                  output coords_finite, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input coords_finite, output ready);
endinterface

interface hsvctm_out_if;
  logic valid;
  logic ready;
  logic keep;

  modport source (output valid, output keep, input ready);
  modport sink   (input valid, input keep, output ready);
endinterface

@@ rtl/hsv_color_threshold_mask.sv @@
// ----------------------------------------------------------------------------
// hsv_color_threshold_mask
// rgb to hsv conversion and hue/saturation/value window test, one item a clock
// ----------------------------------------------------------------------------
// result: an accepted item passes the input register (stage a), the ratio register
//   (stage b) and the keep register (stage c) before it is valid on out_ch
// throughput: one item per cycle, set by the three-stage pipeline with no
//   shared unit; each stage holds while the stage after it is full and stalled
// reset: clears the stage valid bits and all six window registers to 0
// ----------------------------------------------------------------------------
module hsv_color_threshold_mask (
  input  logic                           clk,
  input  logic                           rst_n,
  hsvctm_in_if.sink                      in_ch,
  hsvctm_out_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [hsvctm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hsvctm_pkg::CFG_W-1:0]   cfg_wdata
);
  import hsvctm_pkg::*;

  // window registers
  logic [CFG_W-1:0] hue_low_r, hue_high_r;
  logic [CFG_W-1:0] sat_low_r, sat_high_r;
  logic [CFG_W-1:0] val_low_r, val_high_r;

  // pipeline state
  logic     a_v_r, b_v_r, c_v_r;
  stage_a_t a_r;
  stage_b_t b_r, b_nxt;
  logic     keep_r, keep_nxt;

  // stage advance: a stage takes new data when it is empty or drains this cycle
  logic c_adv, b_adv, a_adv;
  assign c_adv = !c_v_r || out_ch.ready;
  assign b_adv = !b_v_r || c_adv;
  assign a_adv = !a_v_r || b_adv;

  assign in_ch.ready  = a_adv;
  assign out_ch.valid = c_v_r;
  assign out_ch.keep  = keep_r;

  // ---------------------------------------------------------------------------
  // configuration writes, indexes above the list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= '0;
      hue_high_r <= '0;
      sat_low_r  <= '0;
      sat_high_r <= '0;
      val_low_r  <= '0;
      val_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HUE_LOW:  hue_low_r  <= cfg_wdata;
        CFG_HUE_HIGH: hue_high_r <= cfg_wdata;
        CFG_SAT_LOW:  sat_low_r  <= cfg_wdata;
        CFG_SAT_HIGH: sat_high_r <= cfg_wdata;
        CFG_VAL_LOW:  val_low_r  <= cfg_wdata;
        CFG_VAL_HIGH: val_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: max/min, dominant channel and the exact hue and saturation ratios
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]   mx, mn, d;
  logic              red_dom, green_dom;
  logic signed [11:0] t;
  logic signed [16:0] hn_s, hn_fix;
  logic [16:0]       d180;

  always_comb begin
    // ties go red first, then green
    red_dom   = (a_r.red >= a_r.green) && (a_r.red >= a_r.blue);
    green_dom = !red_dom && (a_r.green >= a_r.blue);

    if (red_dom)        mx = a_r.red;
    else if (green_dom) mx = a_r.green;
    else                mx = a_r.blue;

    mn = a_r.red;
    if (a_r.green < mn) mn = a_r.green;
    if (a_r.blue < mn)  mn = a_r.blue;
    d = mx - mn;

    // sextant offset plus signed channel difference, in units of d
    if (red_dom)
      t = $signed({4'b0000, a_r.green}) - $signed({4'b0000, a_r.blue});
    else if (green_dom)
      t = $signed({3'b000, d, 1'b0}) + $signed({4'b0000, a_r.blue})
        - $signed({4'b0000, a_r.red});
    else
      t = $signed({2'b00, d, 2'b00}) + $signed({4'b0000, a_r.red})
        - $signed({4'b0000, a_r.green});

    hn_s   = t * 17'sd30;
    d180   = {9'b0, d} * 17'd180;
    // only the red sextant can go negative, fold it up by a full turn
    hn_fix = hn_s[16] ? (hn_s + $signed(d180)) : hn_s;

    b_nxt.mx     = mx;
    b_nxt.finite = a_r.coords_finite;
    if (mx == '0) begin
      // black point: hue and saturation both 0/1
      b_nxt.sn = '0;
      b_nxt.sd = CH_W'(1);
      b_nxt.hn = '0;
      b_nxt.hd = CH_W'(1);
    end else begin
      b_nxt.sn = {8'b0, d} * 16'd255;
      b_nxt.sd = mx;
      if (d == '0) begin
        // grey point: hue 0/1
        b_nxt.hn = '0;
        b_nxt.hd = CH_W'(1);
      end else begin
        b_nxt.hn = hn_fix[NUM_W-1:0];
        b_nxt.hd = d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: window tests by cross-multiplication
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] hue_lo_prod, hue_hi_prod, sat_lo_prod, sat_hi_prod;
  logic             hue_lo_ok, hue_hi_ok, hue_ok, sat_ok, val_ok;

  always_comb begin
    hue_lo_prod = {8'b0, hue_low_r}  * {8'b0, b_r.hd};
    hue_hi_prod = {8'b0, hue_high_r} * {8'b0, b_r.hd};
    sat_lo_prod = {8'b0, sat_low_r}  * {8'b0, b_r.sd};
    sat_hi_prod = {8'b0, sat_high_r} * {8'b0, b_r.sd};

    hue_lo_ok = hue_lo_prod <= b_r.hn;
    hue_hi_ok = b_r.hn <= hue_hi_prod;
    // wrapped window when the lower bound is above the upper one
    if (hue_low_r <= hue_high_r) hue_ok = hue_lo_ok && hue_hi_ok;
    else                         hue_ok = hue_lo_ok || hue_hi_ok;

    sat_ok = (sat_lo_prod <= b_r.sn) && (b_r.sn <= sat_hi_prod);
    val_ok = (val_low_r <= b_r.mx) && (b_r.mx <= val_high_r);

    keep_nxt = hue_ok && sat_ok && val_ok && b_r.finite;
  end

  // ---------------------------------------------------------------------------
  // pipeline registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= in_ch.valid;
      if (b_adv) b_v_r <= a_v_r;
      if (c_adv) c_v_r <= b_v_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_r.red           <= in_ch.red;
      a_r.green         <= in_ch.green;
      a_r.blue          <= in_ch.blue;
      a_r.coords_finite <= in_ch.coords_finite;
    end
    if (b_adv) b_r    <= b_nxt;
    if (c_adv) keep_r <= keep_nxt;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_input_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n) !in_ch.ready |-> a_v_r
  ) else $error("input stalled with empty input stage");

  a_stage_b_loaded: assert property (
    @(posedge clk) disable iff (!rst_n) (a_v_r && b_adv) |=> b_v_r
  ) else $error("item lost between input stage and stage b");

  a_hue_below_turn: assert property (
    @(posedge clk) disable iff (!rst_n)
      b_v_r |-> ({1'b0, b_r.hn} < ({9'b0, b_r.hd} * 17'd180))
  ) else $error("half-hue numerator out of range");

  a_black_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
      (b_v_r && b_r.mx == '0) |-> (b_r.sn == '0 && b_r.hn == '0)
  ) else $error("black point with nonzero hue or saturation");

endmodule

@@ tb/hsv_color_threshold_mask_tb.sv @@
// ----------------------------------------------------------------------------
// hsv_color_threshold_mask_tb
// self-checking bench for the hsv color threshold mask: a short table of
// directed points over a handful of window settings, then random windows and
// random points, with random idling on both channels. every accepted result
// is compared in order against its typed-in keep or an in-bench hsv window predictor
// ----------------------------------------------------------------------------
module hsv_color_threshold_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvctm_pkg::*;

  // unused register indexes, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int NUM_SETTINGS   = 7;
  localparam int NUM_ROWS       = 24;
  localparam int RAND_PHASES    = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int IDLE_PCT       = 38;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // one set of the six window registers
  typedef struct packed {
    logic [CFG_W-1:0] hue_low;
    logic [CFG_W-1:0] hue_high;
    logic [CFG_W-1:0] sat_low;
    logic [CFG_W-1:0] sat_high;
    logic [CFG_W-1:0] val_low;
    logic [CFG_W-1:0] val_high;
  } hsv_window_t;

  // directed row: window setting, point, and a typed-in keep where obvious
  typedef struct packed {
    logic [2:0]      setting;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            finite;
    logic            typed;
    logic            keep;
  } directed_row_t;

  // one expected keep flag, with its point for the mismatch line
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            finite;
    logic            keep;
  } keep_expect_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  hsvctm_in_if  in_ch ();
  hsvctm_out_if out_ch ();

  hsv_color_threshold_mask DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the window registers, mirrors every write
  hsv_window_t   window_regs;
  keep_expect_t  pending_keeps [$];
  int            mismatch_count;
  int            gap_pct;
  int            stall_pct;

  hsv_window_t   settings      [NUM_SETTINGS];
  directed_row_t directed_rows [NUM_ROWS];

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: exact rational hsv, window tests by cross-multiplication
  // ---------------------------------------------------------------------------
  function automatic logic keep_for_point(input logic [CH_W-1:0] r8,
                                          input logic [CH_W-1:0] g8,
                                          input logic [CH_W-1:0] b8,
                                          input logic fin,
                                          input hsv_window_t w);
    int r, g, b, mx, mn, d, t;
    int hn, hd, sn, sd;
    int hl, hh;
    logic hue_ok, sat_ok, val_ok;
    r = r8; g = g8; b = b8;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // black and grey points fall back to 0/1
    hn = 0; hd = 1; sn = 0; sd = 1;
    if (mx != 0) begin
      sn = 255 * d;
      sd = mx;
      if (d != 0) begin
        // red wins ties over green, green over blue
        if (mx == r) t = g - b;
        else if (mx == g) t = 2 * d + (b - r);
        else t = 4 * d + (r - g);
        hn = 30 * t;
        if (hn < 0) hn += 180 * d;
        hd = d;
      end
    end
    hl = w.hue_low;
    hh = w.hue_high;
    if (hl <= hh) hue_ok = (hl * hd <= hn) && (hn <= hh * hd);
    else hue_ok = (hl * hd <= hn) || (hn <= hh * hd);
    sat_ok = (int'(w.sat_low) * sd <= sn) && (sn <= int'(w.sat_high) * sd);
    val_ok = (int'(w.val_low) <= mx) && (mx <= int'(w.val_high));
    return hue_ok && sat_ok && val_ok && fin;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // configuration port, only used while the pipeline is empty
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // all six registers, plus junk to one spare index in between and the other at the end
  task automatic program_windows(input hsv_window_t w);
    cfg_write(CFG_HUE_LOW, w.hue_low);
    cfg_write(CFG_SPARE_A, CFG_W'($urandom));
    cfg_write(CFG_HUE_HIGH, w.hue_high);
    cfg_write(CFG_SAT_LOW, w.sat_low);
    cfg_write(CFG_SAT_HIGH, w.sat_high);
    cfg_write(CFG_VAL_LOW, w.val_low);
    cfg_write(CFG_VAL_HIGH, w.val_high);
    cfg_write(CFG_SPARE_B, CFG_W'($urandom));
    cfg_we <= 1'b0;
    window_regs = w;
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_keeps.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: random gap, present the item, hold until taken
  // called and returns at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input logic fin,
                            input logic typed, input logic typed_keep);
    keep_expect_t e;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.red           <= r;
    in_ch.green         <= g;
    in_ch.blue          <= b;
    in_ch.coords_finite <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // accepted at this edge, window registers are stable
    e.red    = r;
    e.green  = g;
    e.blue   = b;
    e.finite = fin;
    e.keep   = typed ? typed_keep : keep_for_point(r, g, b, fin, window_regs);
    pending_keeps.insert(pending_keeps.size(), e);
  endtask

  function automatic hsv_window_t random_window(input bit extremes);
    hsv_window_t w;
    if (extremes) begin
      // corner values only: 0, the hue top and the register top
      w.hue_low  = ($urandom_range(0, 2) == 0) ? 8'd0 : ($urandom_range(0, 1) ? 8'd180 : 8'd255);
      w.hue_high = ($urandom_range(0, 2) == 0) ? 8'd0 : ($urandom_range(0, 1) ? 8'd180 : 8'd255);
      w.sat_low  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      w.sat_high = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      w.val_low  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      w.val_high = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end else begin
      // mostly in range and ordered so that points pass, sometimes not
      w.hue_low  = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 255))
                                               : CFG_W'($urandom_range(0, 180));
      w.hue_high = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 255))
                                               : CFG_W'($urandom_range(0, 180));
      w.sat_low  = CFG_W'($urandom_range(0, 160));
      w.sat_high = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 255))
                                               : CFG_W'($urandom_range(w.sat_low, 255));
      w.val_low  = CFG_W'($urandom_range(0, 160));
      w.val_high = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 255))
                                               : CFG_W'($urandom_range(w.val_low, 255));
    end
    return w;
  endfunction

  task automatic send_random_point();
    logic [CH_W-1:0] r, g, b, top, other;
    logic            fin;
    int              mode;
    mode = $urandom_range(0, 9);
    r = CH_W'($urandom); g = CH_W'($urandom); b = CH_W'($urandom);
    fin = ($urandom_range(0, 9) != 0);
    case (mode)
      0: begin
        // grey
        g = r; b = r;
      end
      1: begin
        // two channels share the max, tie-break paths
        top   = CH_W'($urandom);
        other = CH_W'($urandom_range(0, top));
        case ($urandom_range(0, 2))
          0: begin r = top; g = top; b = other; end
          1: begin r = top; b = top; g = other; end
          default: begin g = top; b = top; r = other; end
        endcase
      end
      2: begin
        // black
        r = '0; g = '0; b = '0;
      end
      default: ;
    endcase
    send_point(r, g, b, fin, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // in-order compare against the oldest expectation
  always @(posedge clk) begin
    keep_expect_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_keeps.size() == 0) begin
        report_mismatch($sformatf("unexpected result keep=%0b", out_ch.keep));
      end else begin
        e = pending_keeps.pop_front();
        if (out_ch.keep !== e.keep)
          report_mismatch($sformatf("rgb=%0d,%0d,%0d finite=%0b keep=%0b want %0b",
                                    e.red, e.green, e.blue, e.finite, out_ch.keep, e.keep));
      end
    end
  end

  // watchdog: too many cycles with no item moving on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("hsv_color_threshold_mask regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int cur_setting;
    directed_row_t row;

    // window settings used by the directed table
    settings[0] = '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  };  // reset values
    settings[1] = '{8'd0,   8'd180, 8'd0,   8'd255, 8'd0,   8'd255};  // wide open
    settings[2] = '{8'd170, 8'd10,  8'd0,   8'd255, 8'd0,   8'd255};  // wrapped hue
    settings[3] = '{8'd60,  8'd60,  8'd0,   8'd255, 8'd0,   8'd255};  // equal hue bounds
    settings[4] = '{8'd0,   8'd180, 8'd200, 8'd100, 8'd0,   8'd255};  // inverted sat
    settings[5] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};  // all at top
    settings[6] = '{8'd0,   8'd180, 8'd0,   8'd255, 8'd200, 8'd100};  // inverted val

    // setting, red, green, blue, finite, typed, keep
    directed_rows = '{
      // reset windows: only a black finite point passes
      '{3'd0, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1},
      '{3'd0, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{3'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{3'd0, 8'd1,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
      // wide open: everything finite passes
      '{3'd1, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 1'b1},
      '{3'd1, 8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 1'b1},
      '{3'd1, 8'd0,   8'd0,   8'd255, 1'b1, 1'b1, 1'b1},
      '{3'd1, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1},
      '{3'd1, 8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{3'd1, 8'd128, 8'd64,  8'd200, 1'b1, 1'b0, 1'b0},
      // wrapped hue window around red
      '{3'd2, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 1'b1},
      '{3'd2, 8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 1'b0},
      '{3'd2, 8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 1'b0},
      '{3'd2, 8'd255, 8'd0,   8'd8,   1'b1, 1'b0, 1'b0},
      '{3'd2, 8'd255, 8'd255, 8'd0,   1'b1, 1'b0, 1'b0},
      // single hue value, green exactly on it
      '{3'd3, 8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 1'b1},
      '{3'd3, 8'd0,   8'd255, 8'd1,   1'b1, 1'b0, 1'b0},
      '{3'd3, 8'd0,   8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
      // inverted saturation window rejects all
      '{3'd4, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{3'd4, 8'd100, 8'd100, 8'd100, 1'b1, 1'b1, 1'b0},
      // bounds past the hue range
      '{3'd5, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
      '{3'd5, 8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
      // inverted value window rejects all
      '{3'd6, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{3'd6, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0}
    };

    mismatch_count = 0;
    gap_pct        = IDLE_PCT;
    stall_pct      = IDLE_PCT;
    window_regs    = settings[0];

    // every input known from time zero
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_HUE_LOW;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.red           <= '0;
    in_ch.green         <= '0;
    in_ch.blue          <= '0;
    in_ch.coords_finite <= 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, first rows run on the reset windows
    cur_setting = 0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_rows[i];
      if (int'(row.setting) != cur_setting) begin
        wait_idle();
        program_windows(settings[row.setting]);
        cur_setting = row.setting;
      end
      send_point(row.red, row.green, row.blue, row.finite, row.typed, row.keep);
    end

    // random phases, each with its own windows
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      program_windows(random_window(p == RAND_PHASES - 1));
      // one phase runs flat out on both sides
      gap_pct   = (p == 2) ? 0 : IDLE_PCT;
      stall_pct = (p == 2) ? 0 : IDLE_PCT;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_point();
    end

    // drain, then keep the clock running for anything stray
    gap_pct   = IDLE_PCT;
    stall_pct = IDLE_PCT;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_keeps.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_keeps.size()));

    if (mismatch_count == 0) begin
      $display("hsv_color_threshold_mask regression: pass");
    end else begin
      $display("hsv_color_threshold_mask regression: fail");
    end
    $finish;
  end

endmodule

@@ hsv_color_threshold_mask.f @@
rtl/hsvctm_pkg.sv
rtl/hsvctm_if.sv
rtl/hsv_color_threshold_mask.sv
tb/hsv_color_threshold_mask_tb.sv
